@@ hdl/s_expression_tokenizer_assert.svh @@
// assertion macros for the s-expression tokenizer
`ifndef S_EXPRESSION_TOKENIZER_ASSERT_SVH
`define S_EXPRESSION_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define SEXP_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sexp tokenizer: same-cycle check failed");

// next-cycle implication
`define SEXP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sexp tokenizer: next-cycle check failed");

`endif

@@ hdl/sexp_pkg.sv @@
`timescale 1ns / 1ps

package sexp_pkg;

	localparam int TOK_W        = 16;
	localparam int VAL_W        = 31;
	localparam int POS_BITS_DEF = 16;
	localparam int MAX_ATOM_DEF = 31;
	localparam int QDEPTH       = 4;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'd0;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_DQUOTE = 8'd34;
	localparam logic [7:0] CH_SQUOTE = 8'd39;
	localparam logic [7:0] CH_LPAREN = 8'd40;
	localparam logic [7:0] CH_RPAREN = 8'd41;
	localparam logic [7:0] CH_COMMA  = 8'd44;
	localparam logic [7:0] CH_DOT    = 8'd46;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] CH_LBRACK = 8'd91;
	localparam logic [7:0] CH_RBRACK = 8'd93;

	localparam logic [TOK_W-1:0] LEN_MAX = {TOK_W{1'b1}};
	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

	typedef enum logic [2:0] {
		KIND_OPEN    = 3'd0,
		KIND_CLOSE   = 3'd1,
		KIND_DOT     = 3'd2,
		KIND_COMMA   = 3'd3,
		KIND_SYMBOL  = 3'd4,
		KIND_INTEGER = 3'd5,
		KIND_STRING  = 3'd6,
		KIND_END     = 3'd7
	} token_kind_t;

	typedef struct packed {
		token_kind_t      kind;
		logic [TOK_W-1:0] start;
		logic [TOK_W-1:0] length;
		logic [VAL_W-1:0] value;
		logic             ovf;
		logic             too_long;
		logic             last;
	} token_t;

endpackage

@@ hdl/sexp_core.sv @@
`timescale 1ns / 1ps

module sexp_core import sexp_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF,
	parameter int MAX_ATOM = MAX_ATOM_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_tuple,
	input  logic       char_fire,
	input  logic [7:0] char_code,
	output logic [1:0] push_cnt,
	output token_t     tok0,
	output token_t     tok1
);

	typedef struct packed {
		logic [TOK_W-1:0] len;
		logic             only_digits;
		logic             seen_dot;
		logic [VAL_W-1:0] val;
		logic             sat;
	} atom_t;

	localparam atom_t ATOM_CLEAR = '{len: '0, only_digits: 1'b1, seen_dot: 1'b0,
		val: '0, sat: 1'b0};

	// one atom byte: length, class flags and decimal accumulate
	function automatic atom_t atom_step(atom_t a, logic [7:0] c);
		atom_t            r;
		logic [VAL_W+3:0] v;
		logic             dig;
		r   = a;
		dig = (c >= CH_ZERO) && (c <= CH_NINE);
		v   = ((VAL_W+4)'(a.val) << 3) + ((VAL_W+4)'(a.val) << 1) + (VAL_W+4)'(c[3:0]);
		if (a.len != LEN_MAX) r.len = a.len + 1'b1;
		if (c == CH_DOT) begin
			r.seen_dot = 1'b1;
		end else if (!dig) begin
			r.only_digits = 1'b0;
		end else if (!a.seen_dot) begin
			if (v > (VAL_W+4)'(VAL_MAX)) begin
				r.val = VAL_MAX;
				r.sat = 1'b1;
			end else begin
				r.val = v[VAL_W-1:0];
			end
		end
		return r;
	endfunction

	logic                tuple_q;
	logic                in_atom_q, in_string_q;
	logic [POS_BITS-1:0] pos_q, start_q;
	atom_t               atom_q;

	logic                in_atom_n, in_string_n;
	logic [POS_BITS-1:0] pos_n, start_n;
	atom_t               atom_n;

	logic [7:0]  open_c, close_c;
	logic        is_quote, is_white, is_comma, delim, has_punct;
	token_kind_t punct_kind;
	token_t      atom_tok, str_tok, punct_tok;
	logic [1:0]  cnt;

	always_comb begin
		open_c   = tuple_q ? CH_LBRACK : CH_LPAREN;
		close_c  = tuple_q ? CH_RBRACK : CH_RPAREN;
		is_quote = (char_code == CH_DQUOTE) || (char_code == CH_SQUOTE);
		is_white = (char_code == CH_SPACE) || (char_code == CH_CR) || (char_code == CH_LF);
		is_comma = tuple_q && (char_code == CH_COMMA);
		delim    = (char_code == open_c) || (char_code == close_c) || is_white ||
			is_quote || is_comma;

		atom_tok          = '0;
		atom_tok.kind     = atom_q.only_digits ? KIND_INTEGER : KIND_SYMBOL;
		atom_tok.start    = TOK_W'(start_q);
		atom_tok.length   = atom_q.len;
		atom_tok.value    = atom_q.only_digits ? atom_q.val : '0;
		atom_tok.ovf      = atom_q.only_digits & atom_q.sat;
		atom_tok.too_long = atom_q.len > TOK_W'(MAX_ATOM);

		str_tok        = '0;
		str_tok.kind   = KIND_STRING;
		str_tok.start  = TOK_W'(start_q);
		str_tok.length = atom_q.len;
	end

	always_comb begin
		in_atom_n   = in_atom_q;
		in_string_n = in_string_q;
		pos_n       = pos_q + 1'b1;
		start_n     = start_q;
		atom_n      = atom_q;
		tok0        = '0;
		tok1        = '0;
		punct_tok   = '0;
		cnt         = 2'd0;
		has_punct   = 1'b0;
		punct_kind  = KIND_OPEN;

		if (char_code == CH_NUL) begin
			// flush the pending token, then end of text
			if (in_string_q) begin
				tok0 = str_tok;
				cnt  = 2'd1;
			end else if (in_atom_q) begin
				tok0 = atom_tok;
				cnt  = 2'd1;
			end
			has_punct   = 1'b1;
			punct_kind  = KIND_END;
			in_atom_n   = 1'b0;
			in_string_n = 1'b0;
			start_n     = '0;
			atom_n      = ATOM_CLEAR;
			pos_n       = '0;
		end else if (in_string_q) begin
			if (is_quote) begin
				tok0        = str_tok;
				cnt         = 2'd1;
				in_string_n = 1'b0;
			end else if (atom_q.len != LEN_MAX) begin
				atom_n.len = atom_q.len + 1'b1;
			end
		end else begin
			if (in_atom_q && delim) begin
				tok0      = atom_tok;
				cnt       = 2'd1;
				in_atom_n = 1'b0;
			end
			if (in_atom_q && !delim) begin
				atom_n = atom_step(atom_q, char_code);
			end else if (char_code == open_c) begin
				has_punct  = 1'b1;
				punct_kind = KIND_OPEN;
			end else if (char_code == close_c) begin
				has_punct  = 1'b1;
				punct_kind = KIND_CLOSE;
			end else if (is_comma) begin
				has_punct  = 1'b1;
				punct_kind = KIND_COMMA;
			end else if (char_code == CH_DOT) begin
				has_punct  = !tuple_q;
				punct_kind = KIND_DOT;
			end else if (is_quote) begin
				in_string_n = 1'b1;
				start_n     = pos_q + 1'b1;
				atom_n.len  = '0;
			end else if (!is_white) begin
				in_atom_n = 1'b1;
				start_n   = pos_q;
				atom_n    = atom_step(ATOM_CLEAR, char_code);
			end
		end

		if (has_punct) begin
			punct_tok.kind = punct_kind;
			if (cnt == 2'd0) tok0 = punct_tok;
			else             tok1 = punct_tok;
			cnt = cnt + 2'd1;
		end

		if (cnt == 2'd1) tok0.last = 1'b1;
		if (cnt == 2'd2) tok1.last = 1'b1;

		push_cnt = char_fire ? cnt : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuple_q     <= 1'b0;
			in_atom_q   <= 1'b0;
			in_string_q <= 1'b0;
			pos_q       <= '0;
			start_q     <= '0;
			atom_q      <= ATOM_CLEAR;
		end else begin
			if (cfg_we) tuple_q <= cfg_tuple;
			if (char_fire) begin
				in_atom_q   <= in_atom_n;
				in_string_q <= in_string_n;
				pos_q       <= pos_n;
				start_q     <= start_n;
				atom_q      <= atom_n;
			end
		end
	end

endmodule

@@ hdl/sexp_outq.sv @@
`timescale 1ns / 1ps

module sexp_outq import sexp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  token_t     tok0,
	input  token_t     tok1,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output token_t     out_tok
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	token_t          mem_q [QDEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            pop;

	// room for two more tokens is needed before taking a byte
	assign in_ready  = cnt_q <= CW'(QDEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign out_tok   = mem_q[rd_q];
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_q] <= tok0;
		if (push_cnt == 2'd2) mem_q[PW'(wr_q + 1'b1)] <= tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push_cnt);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + CW'(push_cnt) - CW'(pop);
		end
	end

endmodule

@@ hdl/s_expression_tokenizer.sv @@
`timescale 1ns / 1ps
// channel   | direction | handshake                   | payload
// char      | in        | char_valid / char_ready     | char_code
// token     | out       | token_valid / token_ready   | token_kind .. last_of_run
// config    | in        | tuple_mode_we (no wait)     | tuple_mode
//
// one byte is taken per cycle while char_ready is high; its tokens (zero, one or two) are written into a
// four-entry token queue in the same edge and leave it one per cycle while token_ready is high
// char_ready is low while the queue has fewer than two free slots, so when every byte makes
// two tokens, the byte side is held back to the pace of the token side
// the tokens appear on the port in the cycle after the byte is taken at the earliest
// reset clears the tokenizer state, the queue and tuple_mode; no clearing pass

`include "s_expression_tokenizer_assert.svh"

module s_expression_tokenizer import sexp_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF,
	parameter int MAX_ATOM = MAX_ATOM_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration
	input  logic             tuple_mode_we,
	input  logic             tuple_mode,
	// byte request
	input  logic             char_valid,
	output logic             char_ready,
	input  logic [7:0]       char_code,
	// token request
	output logic             token_valid,
	input  logic             token_ready,
	output logic [2:0]       token_kind,
	output logic [TOK_W-1:0] token_start,
	output logic [TOK_W-1:0] token_length,
	output logic [VAL_W-1:0] int_value,
	output logic             int_overflow,
	output logic             atom_too_long,
	output logic             last_of_run
);

	logic       char_fire;
	logic [1:0] push_cnt;
	token_t     tok0, tok1, out_tok;

	assign char_fire = char_valid & char_ready;

	// decode and tokenizer state: one pass per byte
	sexp_core #(
		.POS_BITS(POS_BITS),
		.MAX_ATOM(MAX_ATOM)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (tuple_mode_we),
		.cfg_tuple (tuple_mode),
		.char_fire (char_fire),
		.char_code (char_code),
		.push_cnt  (push_cnt),
		.tok0      (tok0),
		.tok1      (tok1)
	);

	// token queue separates the byte side from the token side
	sexp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.tok0      (tok0),
		.tok1      (tok1),
		.in_ready  (char_ready),
		.out_valid (token_valid),
		.out_ready (token_ready),
		.out_tok   (out_tok)
	);

	assign token_kind    = out_tok.kind;
	assign token_start   = out_tok.start;
	assign token_length  = out_tok.length;
	assign int_value     = out_tok.value;
	assign int_overflow  = out_tok.ovf;
	assign atom_too_long = out_tok.too_long;
	assign last_of_run   = out_tok.last;

	// end of text always closes the run of its byte
	`SEXP_ASSERT_IMPLY(a_end_is_last, clk, arst_n, token_valid && (token_kind == KIND_END), last_of_run)
	// a saturated value only on integers, pinned at the maximum
	`SEXP_ASSERT_IMPLY(a_ovf_integer, clk, arst_n, token_valid && int_overflow, (token_kind == KIND_INTEGER) && (int_value == VAL_MAX))
	// a zero byte always leaves at least its end token queued
	`SEXP_ASSERT_NEXT(a_nul_emits, clk, arst_n, char_fire && (char_code == CH_NUL), token_valid)
	// back-pressure on bytes only when tokens are waiting
	`SEXP_ASSERT_IMPLY(a_stall_has_tokens, clk, arst_n, !char_ready, token_valid)

endmodule

@@ dv/s_expression_tokenizer_checker.sv @@
`timescale 1ns / 1ps

module s_expression_tokenizer_checker import sexp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tuple_mode_we,
	input  logic             tuple_mode,
	input  logic             char_valid,
	input  logic             char_ready,
	input  logic [7:0]       char_code,
	input  logic             token_valid,
	input  logic             token_ready,
	input  logic [2:0]       token_kind,
	input  logic [TOK_W-1:0] token_start,
	input  logic [TOK_W-1:0] token_length,
	input  logic [VAL_W-1:0] int_value,
	input  logic             int_overflow,
	input  logic             atom_too_long,
	input  logic             last_of_run,
	output int               errors,
	output int               pending
);

	localparam int MAX_ATOM = MAX_ATOM_DEF;

	// tokenizer state as the block should hold it
	logic                    syntax_tuple;
	logic                    in_atom;
	logic                    in_string;
	logic [POS_BITS_DEF-1:0] position;
	logic [TOK_W-1:0]        start_offset;
	logic [TOK_W-1:0]        run_length;
	logic                    only_digits;
	logic                    seen_dot;
	logic [31:0]             value_acc;
	logic                    value_sat;

	token_t expected_tokens[$];

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 100)
			$display("[%0t] token mismatch: %s", $time, what);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	function automatic void clear_token_state();
		in_atom      = 1'b0;
		in_string    = 1'b0;
		start_offset = '0;
		run_length   = '0;
		only_digits  = 1'b1;
		seen_dot     = 1'b0;
		value_acc    = '0;
		value_sat    = 1'b0;
	endfunction

	function automatic token_t make_token(input token_kind_t kind,
		input logic [TOK_W-1:0] start, input logic [TOK_W-1:0] length,
		input logic [VAL_W-1:0] value, input logic ovf, input logic too_long);
		token_t t;
		t.kind     = kind;
		t.start    = start;
		t.length   = length;
		t.value    = value;
		t.ovf      = ovf;
		t.too_long = too_long;
		t.last     = 1'b0;
		return t;
	endfunction

	function automatic token_t atom_token();
		logic too_long;
		too_long = (run_length > TOK_W'(MAX_ATOM));
		if (only_digits)
			return make_token(KIND_INTEGER, start_offset, run_length,
				value_acc[VAL_W-1:0], value_sat, too_long);
		return make_token(KIND_SYMBOL, start_offset, run_length, '0, 1'b0, too_long);
	endfunction

	function automatic void absorb_atom_byte(input logic [7:0] c);
		logic [63:0] grown;
		if (run_length != LEN_MAX)
			run_length = run_length + 1'b1;
		if (c == CH_DOT) begin
			seen_dot = 1'b1;
		end else if (c < CH_ZERO || c > CH_NINE) begin
			only_digits = 1'b0;
		end else if (!seen_dot) begin
			// only digits ahead of the first dot count toward the value
			grown = 64'(value_acc) * 64'd10 + 64'(c - CH_ZERO);
			if (grown > 64'(VAL_MAX)) begin
				grown     = 64'(VAL_MAX);
				value_sat = 1'b1;
			end
			value_acc = grown[31:0];
		end
	endfunction

	function automatic void tokenize_byte(input logic [7:0] c);
		token_t     made[2];
		int         n;
		logic [7:0] open_c;
		logic [7:0] close_c;
		logic       quote;
		logic       white;
		logic       comma;
		logic       delim;
		n       = 0;
		open_c  = syntax_tuple ? CH_LBRACK : CH_LPAREN;
		close_c = syntax_tuple ? CH_RBRACK : CH_RPAREN;
		quote   = (c == CH_DQUOTE || c == CH_SQUOTE);
		white   = (c == CH_SPACE || c == CH_CR || c == CH_LF);
		comma   = syntax_tuple && c == CH_COMMA;
		if (c == CH_NUL) begin
			if (in_string) begin
				made[n] = make_token(KIND_STRING, start_offset, run_length, '0, 1'b0, 1'b0);
				n++;
			end else if (in_atom) begin
				made[n] = atom_token();
				n++;
			end
			made[n] = make_token(KIND_END, '0, '0, '0, 1'b0, 1'b0);
			n++;
			clear_token_state();
			position = '0;
		end else begin
			if (in_string) begin
				if (quote) begin
					made[n] = make_token(KIND_STRING, start_offset, run_length, '0, 1'b0,
						1'b0);
					n++;
					in_string = 1'b0;
				end else if (run_length != LEN_MAX) begin
					run_length = run_length + 1'b1;
				end
			end else begin
				delim = (c == open_c || c == close_c || white || quote || comma);
				if (in_atom && delim) begin
					made[n] = atom_token();
					n++;
					in_atom = 1'b0;
				end
				if (in_atom) begin
					absorb_atom_byte(c);
				end else if (c == open_c) begin
					made[n] = make_token(KIND_OPEN, '0, '0, '0, 1'b0, 1'b0);
					n++;
				end else if (c == close_c) begin
					made[n] = make_token(KIND_CLOSE, '0, '0, '0, 1'b0, 1'b0);
					n++;
				end else if (comma) begin
					made[n] = make_token(KIND_COMMA, '0, '0, '0, 1'b0, 1'b0);
					n++;
				end else if (c == CH_DOT) begin
					if (!syntax_tuple) begin
						made[n] = make_token(KIND_DOT, '0, '0, '0, 1'b0, 1'b0);
						n++;
					end
				end else if (quote) begin
					in_string    = 1'b1;
					start_offset = position + 1'b1;
					run_length   = '0;
				end else if (!white) begin
					clear_token_state();
					in_atom      = 1'b1;
					start_offset = position;
					run_length   = '0;
					absorb_atom_byte(c);
				end
			end
			position = position + 1'b1;
		end
		if (n > 0)
			made[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_tokens.push_back(made[i]);
	endfunction

	task automatic check_token();
		token_t want;
		if (expected_tokens.size() == 0) begin
			report_mismatch($sformatf("kind %0d arrived with none expected", token_kind));
		end else begin
			want = expected_tokens.pop_front();
			compare_field("kind", 32'(token_kind), 32'(want.kind));
			compare_field("start", 32'(token_start), 32'(want.start));
			compare_field("length", 32'(token_length), 32'(want.length));
			compare_field("int_value", 32'(int_value), 32'(want.value));
			compare_field("int_overflow", 32'(int_overflow), 32'(want.ovf));
			compare_field("atom_too_long", 32'(atom_too_long), 32'(want.too_long));
			compare_field("last_of_run", 32'(last_of_run), 32'(want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			syntax_tuple = 1'b0;
			position     = '0;
			clear_token_state();
			expected_tokens.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (token_valid && token_ready)
				check_token();
			if (char_valid && char_ready)
				tokenize_byte(char_code);
			if (tuple_mode_we)
				syntax_tuple = tuple_mode;
			pending = expected_tokens.size();
		end
	end

endmodule

@@ dv/tb_s_expression_tokenizer.sv @@
`timescale 1ns / 1ps

module tb_s_expression_tokenizer;
	import sexp_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             tuple_mode_we;
	logic             tuple_mode;
	logic             char_valid;
	logic             char_ready;
	logic [7:0]       char_code;
	logic             token_valid;
	logic             token_ready = 1'b0;
	logic [2:0]       token_kind;
	logic [TOK_W-1:0] token_start;
	logic [TOK_W-1:0] token_length;
	logic [VAL_W-1:0] int_value;
	logic             int_overflow;
	logic             atom_too_long;
	logic             last_of_run;

	int   errors;
	int   pending;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   sent_items;
	// syntax the generator writes for, kept in step with the register
	logic syntax_tuple;

	s_expression_tokenizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tuple_mode_we(tuple_mode_we),
		.tuple_mode   (tuple_mode),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_code    (char_code),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.int_value    (int_value),
		.int_overflow (int_overflow),
		.atom_too_long(atom_too_long),
		.last_of_run  (last_of_run)
	);

	// predicts every token from the accepted bytes and compares in order
	s_expression_tokenizer_checker token_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.tuple_mode_we(tuple_mode_we),
		.tuple_mode   (tuple_mode),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_code    (char_code),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.int_value    (int_value),
		.int_overflow (int_overflow),
		.atom_too_long(atom_too_long),
		.last_of_run  (last_of_run),
		.errors       (errors),
		.pending      (pending)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// token receiver stalls at random, one decision per falling edge
	always @(negedge clk) begin
		token_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// hard stop in case a request never completes
	initial begin
		#(20_000_000);
		$display("FAIL s_expression_tokenizer");
		$finish;
	end

	function automatic logic is_delim(input logic [7:0] c);
		return c == (syntax_tuple ? CH_LBRACK : CH_LPAREN) ||
			c == (syntax_tuple ? CH_RBRACK : CH_RPAREN) ||
			c == CH_SPACE || c == CH_CR || c == CH_LF ||
			c == CH_DQUOTE || c == CH_SQUOTE ||
			(syntax_tuple && c == CH_COMMA);
	endfunction

	// any nonzero byte other than a quote; atom bytes also avoid delimiters
	function automatic logic [7:0] pick_byte(input logic allow_delims);
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == CH_DQUOTE || c == CH_SQUOTE || (!allow_delims && is_delim(c)));
		return c;
	endfunction

	function automatic logic [7:0] pick_quote();
		return $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
	endfunction

	// one byte request; called at a falling edge, returns at a falling edge
	// with valid still high so back-to-back bytes never drop it
	task automatic send_byte(input logic [7:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_code  <= c;
		@(posedge clk);
		while (!char_ready)
			@(posedge clk);
		@(negedge clk);
		sent_items++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// register writes only with the tokenizer idle: sender parked, every
	// predicted token delivered, then a short pause for bytes with no token
	task automatic set_syntax(input logic tuple);
		char_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		tuple_mode_we <= 1'b1;
		tuple_mode    <= tuple;
		@(negedge clk);
		tuple_mode_we <= 1'b0;
		syntax_tuple = tuple;
	endtask

	// one piece of well-formed text with random content, or some noise
	task automatic send_form();
		int pick;
		int len;
		pick = $urandom_range(99);
		if (pick < 15) begin
			send_byte(syntax_tuple ? CH_LBRACK : CH_LPAREN);
		end else if (pick < 30) begin
			send_byte(syntax_tuple ? CH_RBRACK : CH_RPAREN);
		end else if (pick < 48) begin
			// number, sometimes past the atom limit or the value range
			len = ($urandom_range(9) == 0) ? $urandom_range(32, 40) : $urandom_range(1, 14);
			send_byte(CH_ZERO + 8'($urandom_range(9)));
			repeat (len - 1)
				send_byte(($urandom_range(11) == 0) ? CH_DOT : CH_ZERO + 8'($urandom_range(9)));
		end else if (pick < 62) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
			repeat (len)
				send_byte(pick_byte(1'b0));
		end else if (pick < 72) begin
			// string with any content; now and then left open for a zero byte
			send_byte(pick_quote());
			repeat ($urandom_range(0, 8))
				send_byte(pick_byte(1'b1));
			if ($urandom_range(9) != 0)
				send_byte(pick_quote());
		end else if (pick < 82) begin
			case ($urandom_range(4))
				0: send_byte(CH_SPACE);
				1: send_byte(CH_CR);
				2: send_byte(CH_LF);
				3: send_byte(CH_COMMA);
				default: send_byte(CH_DOT);
			endcase
		end else if (pick < 87) begin
			send_byte(CH_NUL);
		end else begin
			send_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic send_random(input int count);
		int target;
		target = sent_items + count;
		while (sent_items < target)
			send_form();
	endtask

	initial begin
		arst_n        = 1'b0;
		tuple_mode_we = 1'b0;
		tuple_mode    = 1'b0;
		char_valid    = 1'b0;
		char_code     = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sent_items    = 0;
		syntax_tuple  = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// list syntax: number with a dot inside, quote ending an atom,
		// string closed by the other quote, dot token, cr/lf as white space, tab
		// and 0xff as atom bytes, zero byte inside an open string
		set_syntax(1'b0);
		send_text("(12.5 x\"hi'.)");
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(8'h09);
		send_byte(8'hff);
		send_text("'ab");
		send_byte(CH_NUL);

		// tuple syntax: comma right after an atom, lone dot ignored,
		// parenthesis as an atom byte
		set_syntax(1'b1);
		send_text("[7,.(]");
		send_byte(CH_NUL);

		// sender idles 27 percent, receiver 46
		send_idle_pct = 27;
		recv_idle_pct = 46;
		set_syntax(1'b0);
		send_random(280);

		// and the other way round
		send_idle_pct = 46;
		recv_idle_pct = 27;
		set_syntax(1'b1);
		send_random(280);

		// no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_syntax(1'b0);
		send_random(145);
		set_syntax(1'b1);
		send_random(145);
		send_byte(CH_NUL);

		char_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("PASS s_expression_tokenizer");
		else
			$display("FAIL s_expression_tokenizer");
		$finish;
	end

endmodule

@@ s_expression_tokenizer.f @@
+incdir+hdl
hdl/sexp_pkg.sv
hdl/sexp_core.sv
hdl/sexp_outq.sv
hdl/s_expression_tokenizer.sv
dv/s_expression_tokenizer_checker.sv
dv/tb_s_expression_tokenizer.sv
